/* design/assert_macros.svh */
// Assertion macros used by the checker file dam_checker.sv.
// Each macro expects clk and rst_n in scope; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clk edge outside of reset.
`define DAM_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition implies another in the next cycle.
`define DAM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/dam_pkg.sv */
// Shared types and constants for the diagonal associative memory.
// No dependencies; imported by every module of the block but dam_ram.
package dam_pkg;

    localparam int WORD_W  = 16;                  // bits per word and per row
    localparam int N_ROWS  = 16;                  // rows (and words) in the matrix
    localparam int ROW_W   = $clog2(N_ROWS);      // row / word index width
    localparam int KEY_W   = 3;                   // key compared with word bits 0..2
    localparam int FIELD_W = 11;                  // word bits 0..10 kept for the add
    localparam int NIB_W   = 4;                   // width of each add operand
    localparam int SUM_W   = NIB_W + 1;           // add result, word bits 11..15

    typedef enum logic [2:0] {
        KIND_READ   = 3'd0,
        KIND_WRITE  = 3'd1,
        KIND_LOGIC  = 3'd2,
        KIND_ADD    = 3'd3,
        KIND_COLUMN = 3'd4
    } kind_t;

    typedef enum logic [1:0] {
        FN_XOR      = 2'd0,
        FN_XNOR     = 2'd1,
        FN_NOT_B    = 2'd2,
        FN_OR_NOT_B = 2'd3
    } logic_fn_t;

    typedef struct packed {
        logic [2:0]        kind;
        logic [ROW_W-1:0]  index_a;
        logic [ROW_W-1:0]  index_b;
        logic [ROW_W-1:0]  index_dest;
        logic [1:0]        logic_func;
        logic [WORD_W-1:0] word_in;
        logic [KEY_W-1:0]  key;
    } item_t;

    typedef struct packed {
        logic [WORD_W-1:0] word_out;
        logic [WORD_W-1:0] match_mask;
    } result_t;

    // Row returning from the RAM this cycle
    typedef struct packed {
        logic             vld;
        logic             upd;   // 1: update pass (write back), 0: scan pass
        logic [ROW_W-1:0] row;
    } row_ctrl_t;

    // Row write-back to the RAM
    typedef struct packed {
        logic              en;
        logic [ROW_W-1:0]  addr;
        logic [WORD_W-1:0] data;
    } row_wr_t;

endpackage

/* design/dam_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module dam_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

/* design/dam_datapath.sv */
// Row datapath: gathers words and columns from scanned rows and builds
// modified rows for write-back. Depends on dam_pkg.
module dam_datapath
    import dam_pkg::*;
(
    input  logic              clk,
    input  row_ctrl_t         ctrl,
    input  item_t             item,
    input  logic [WORD_W-1:0] rd_data,
    output row_wr_t           wr,
    output result_t           result
);

    logic [WORD_W-1:0]  word_a_reg;
    logic [WORD_W-1:0]  word_b_reg;
    logic [WORD_W-1:0]  col_reg;
    logic [FIELD_W-1:0] fld_reg [N_ROWS];

    logic [ROW_W-1:0]   k_a;
    logic [ROW_W-1:0]   k_b;
    logic [ROW_W-1:0]   k_d;
    logic [ROW_W-1:0]   k_w   [N_ROWS];
    logic [ROW_W-1:0]   nk_w  [N_ROWS];
    logic [SUM_W-1:0]   sum_w [N_ROWS];
    logic [WORD_W-1:0]  match;
    logic [WORD_W-1:0]  logic_res;
    logic [WORD_W-1:0]  row_new;

    // Bit position of the returning row within each word of interest
    always_comb
    begin
        k_a = ctrl.row - item.index_a;
        k_b = ctrl.row - item.index_b;
        k_d = ctrl.row - item.index_dest;
        for (int w = 0; w < N_ROWS; w++)
        begin
            k_w[w]  = ctrl.row - ROW_W'(w);
            nk_w[w] = ~k_w[w];
        end
    end

    // Key match and field sum per word; word bit 0 is the MSB of each field
    always_comb
    begin
        for (int w = 0; w < N_ROWS; w++)
        begin
            match[w] = ({fld_reg[w][0], fld_reg[w][1], fld_reg[w][2]} == item.key);
            sum_w[w] = {1'b0, fld_reg[w][3], fld_reg[w][4], fld_reg[w][5], fld_reg[w][6]}
                     + {1'b0, fld_reg[w][7], fld_reg[w][8], fld_reg[w][9], fld_reg[w][10]};
        end
    end

    // Logic function on the gathered operands
    always_comb
    begin
        case (item.logic_func)
            FN_XOR:      logic_res = word_a_reg ^ word_b_reg;
            FN_XNOR:     logic_res = ~(word_a_reg ^ word_b_reg);
            FN_NOT_B:    logic_res = ~word_b_reg;
            FN_OR_NOT_B: logic_res = word_a_reg | ~word_b_reg;
            default:     logic_res = '0;
        endcase
    end

    // Modify the returning row for the update pass
    always_comb
    begin
        row_new = rd_data;
        case (item.kind)
            KIND_WRITE:
            begin
                row_new[item.index_a] = item.word_in[~k_a];
            end
            KIND_LOGIC:
            begin
                row_new[item.index_dest] = logic_res[~k_d];
            end
            KIND_ADD:
            begin
                for (int w = 0; w < N_ROWS; w++)
                begin
                    if (k_w[w] >= ROW_W'(FIELD_W) && match[w])
                    begin
                        row_new[w] = sum_w[w][nk_w[w][2:0]];
                    end
                end
            end
            default:
            begin
                row_new = rd_data;
            end
        endcase
        wr.en   = ctrl.vld && ctrl.upd;
        wr.addr = ctrl.row;
        wr.data = row_new;
    end

    // Gather operand words, column and add fields during the scan pass
    always_ff @(posedge clk)
    begin
        if (ctrl.vld && !ctrl.upd)
        begin
            word_a_reg[~k_a] <= rd_data[item.index_a];
            word_b_reg[~k_b] <= rd_data[item.index_b];
            col_reg[~k_a]    <= rd_data[k_a];
            for (int w = 0; w < N_ROWS; w++)
            begin
                if (k_w[w] < ROW_W'(FIELD_W))
                begin
                    fld_reg[w][k_w[w]] <= rd_data[w];
                end
            end
        end
    end

    // Select the result word
    always_comb
    begin
        result.word_out   = '0;
        result.match_mask = '0;
        case (item.kind)
            KIND_READ:   result.word_out   = word_a_reg;
            KIND_COLUMN: result.word_out   = col_reg;
            KIND_ADD:    result.match_mask = match;
            default:     result.word_out   = '0;
        endcase
    end

endmodule

/* design/diagonal_associative_memory.sv */
// Diagonal-addressed associative memory, 16 x 16 bits, top level.
// Depends on dam_pkg, dam_ram and dam_datapath.
//
// Use: present a command word on in_data with in_valid; it is taken when
// in_ready is high. One result word per command appears on out_data with
// out_valid and is held until out_ready takes it.
// The matrix lives in a 16-row RAM; every command of a used kind sweeps all
// rows, one row per cycle through the single registered read port.
// Read word, read column and write word take one pass over the rows;
// logic op and masked add take a scan pass and an update pass.
// Unused command kinds skip the rows and give a zero result.
// One command is in flight at a time; in_ready returns as soon as the
// result is loaded into the output register, so the next command may
// start while that result still waits on a stalled receiver. A finished
// command whose result cannot be loaded holds in place until it can.
// Reset clears per-row valid bits, so the matrix reads as all zeros with
// no clearing pass; the block is ready right after reset.
module diagonal_associative_memory
    import dam_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_ready,
    input  item_t   in_data,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t out_data
);

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_SCAN   = 5'b00010,
        ST_UPDATE = 5'b00100,
        ST_FINISH = 5'b01000,
        ST_DONE   = 5'b10000
    } state_t;

    state_t            state_reg, state_next;
    logic [ROW_W-1:0]  cnt_reg, cnt_next;
    logic              pipe_vld_reg;
    logic              pipe_upd_reg;
    logic [ROW_W-1:0]  pipe_row_reg;
    logic              rd_ok_reg;
    logic [N_ROWS-1:0] row_vld_reg;
    logic              out_vld_reg, out_vld_next;
    result_t           out_data_reg;
    item_t             item_reg;

    logic              accept;
    logic              issue;
    logic              out_load;
    logic [WORD_W-1:0] ram_q;
    logic [WORD_W-1:0] rd_data;
    row_ctrl_t         ctrl;
    row_wr_t           wr;
    result_t           result;

    assign in_ready  = (state_reg == ST_IDLE);
    assign accept    = in_valid && in_ready;
    assign issue     = (state_reg == ST_SCAN) || (state_reg == ST_UPDATE);
    assign out_load  = (state_reg == ST_DONE) && (!out_vld_reg || out_ready);
    assign out_valid = out_vld_reg;
    assign out_data  = out_data_reg;

    // Sequence the passes over the rows
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    case (in_data.kind)
                        KIND_WRITE:  state_next = ST_UPDATE;
                        KIND_READ,
                        KIND_LOGIC,
                        KIND_ADD,
                        KIND_COLUMN: state_next = ST_SCAN;
                        default:     state_next = ST_DONE;
                    endcase
                end
            end
            ST_SCAN:
            begin
                if (cnt_reg == ROW_W'(N_ROWS - 1))
                begin
                    if (item_reg.kind == KIND_LOGIC || item_reg.kind == KIND_ADD)
                    begin
                        state_next = ST_UPDATE;
                    end
                    else
                    begin
                        state_next = ST_FINISH;
                    end
                end
            end
            ST_UPDATE:
            begin
                if (cnt_reg == ROW_W'(N_ROWS - 1))
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
        cnt_next = issue ? cnt_reg + 1'b1 : '0;
    end

    // Hold the output word until taken
    always_comb
    begin
        if (out_load)
        begin
            out_vld_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_vld_next = 1'b0;
        end
        else
        begin
            out_vld_next = out_vld_reg;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            cnt_reg      <= '0;
            pipe_vld_reg <= 1'b0;
            out_vld_reg  <= 1'b0;
            row_vld_reg  <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            pipe_vld_reg <= issue;
            out_vld_reg  <= out_vld_next;
            if (wr.en)
            begin
                row_vld_reg[wr.addr] <= 1'b1;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= in_data;
        end
        if (out_load)
        begin
            out_data_reg <= result;
        end
        pipe_upd_reg <= (state_reg == ST_UPDATE);
        pipe_row_reg <= cnt_reg;
        rd_ok_reg    <= row_vld_reg[cnt_reg];
    end

    // Rows never written read as zero
    assign rd_data = rd_ok_reg ? ram_q : '0;

    assign ctrl.vld = pipe_vld_reg;
    assign ctrl.upd = pipe_upd_reg;
    assign ctrl.row = pipe_row_reg;

    dam_ram #(
        .WIDTH (WORD_W),
        .DEPTH (N_ROWS)
    ) u_ram (
        .clk   (clk),
        .we    (wr.en),
        .waddr (wr.addr),
        .wdata (wr.data),
        .raddr (cnt_reg),
        .rdata (ram_q)
    );

    dam_datapath u_datapath (
        .clk     (clk),
        .ctrl    (ctrl),
        .item    (item_reg),
        .rd_data (rd_data),
        .wr      (wr),
        .result  (result)
    );

endmodule

/* design/dam_checker.sv */
// Port-level checker for the diagonal associative memory, with its bind.
// Depends on dam_pkg and assert_macros.svh.
`include "assert_macros.svh"

module dam_checker
    import dam_pkg::*;
(
    input logic    clk,
    input logic    rst_n,
    input logic    in_valid,
    input logic    in_ready,
    input item_t   in_data,
    input logic    out_valid,
    input logic    out_ready,
    input result_t out_data
);

    // A stalled result word holds
    `DAM_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data), "stalled result word changed")

    // One command at a time: accepting a word drops ready
    `DAM_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "ready stayed high after accept")

    // A new result appears only while the input side is busy
    `DAM_ASSERT(a_result_from_busy, $rose(out_valid) |-> $past(!in_ready), "result appeared while idle")

    // A match mask and a read word never come together
    `DAM_ASSERT(a_mask_or_word, out_valid && (out_data.match_mask != '0) |-> (out_data.word_out == '0), "match mask with nonzero word")

endmodule

bind diagonal_associative_memory dam_checker u_dam_checker (.*);

/* test/diagonal_associative_memory_tb.sv */
// Self-checking testbench for diagonal_associative_memory: a scoreboard class
// keeps its own copy of the sixteen words and predicts every result word.
// Depends on dam_pkg and the diagonal_associative_memory RTL only.
module diagonal_associative_memory_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import dam_pkg::*;

    // Command kinds the block leaves unused
    localparam logic [2:0] KIND_SPARE_5 = 3'd5;
    localparam logic [2:0] KIND_SPARE_6 = 3'd6;
    localparam logic [2:0] KIND_SPARE_7 = 3'd7;

    localparam int HOLD_OFF_CYCLES = 300;
    localparam int DRAIN_CYCLES    = 60;

    // Word-level copy of the matrix plus the FIFO of result words still due.
    // Words are kept MSB-first: word bit k is value bit 15-k.
    class dam_matrix_model;
        logic [WORD_W-1:0] words [N_ROWS];
        result_t           results_due [$];
        int unsigned       errors;

        function new();
            foreach (words[w])
                words[w] = '0;
            errors = 0;
        endfunction

        // Apply one accepted command and queue the result word it produces
        function void note_command(item_t cmd);
            result_t           res;
            logic [WORD_W-1:0] op_a;
            logic [WORD_W-1:0] op_b;
            logic [WORD_W-1:0] val;
            logic [SUM_W-1:0]  total;
            res = '0;
            case (cmd.kind)
                KIND_READ:
                    res.word_out = words[cmd.index_a];
                KIND_WRITE:
                    words[cmd.index_a] = cmd.word_in;
                KIND_LOGIC:
                begin
                    // read both operands before the destination changes
                    op_a = words[cmd.index_a];
                    op_b = words[cmd.index_b];
                    case (cmd.logic_func)
                        FN_XOR:   val = op_a ^ op_b;
                        FN_XNOR:  val = ~(op_a ^ op_b);
                        FN_NOT_B: val = ~op_b;
                        default:  val = op_a | ~op_b;
                    endcase
                    words[cmd.index_dest] = val;
                end
                KIND_ADD:
                begin
                    for (int w = 0; w < N_ROWS; w++)
                    begin
                        val = words[w];
                        if (val[15:13] == cmd.key)
                        begin
                            total    = val[12:9] + val[8:5];
                            words[w] = {val[15:5], total};
                            res.match_mask[w] = 1'b1;
                        end
                    end
                end
                KIND_COLUMN:
                begin
                    // bit i of column c sits in word i at word bit c
                    for (int i = 0; i < N_ROWS; i++)
                        res.word_out[15 - i] = words[i][15 - cmd.index_a];
                end
                default:
                    ;
            endcase
            results_due = {results_due, res};
        endfunction

        // Compare one accepted result word with the oldest prediction
        function void check_result(result_t got);
            result_t want;
            if (results_due.size() == 0)
            begin
                $error("unexpected result word: word_out %h, match_mask %h",
                       got.word_out, got.match_mask);
                errors++;
                return;
            end
            want = results_due.pop_front();
            if (got.word_out !== want.word_out)
            begin
                $error("word_out mismatch: expected %h, actual %h", want.word_out, got.word_out);
                errors++;
            end
            if (got.match_mask !== want.match_mask)
            begin
                $error("match_mask mismatch: expected %h, actual %h",
                       want.match_mask, got.match_mask);
                errors++;
            end
        endfunction
    endclass

    logic    clk = 1'b0;
    logic    rst_n;
    logic    in_valid;
    logic    in_ready;
    item_t   in_data;
    logic    out_valid;
    logic    out_ready;
    result_t out_data;

    dam_matrix_model model = new();
    int unsigned     tx_idle_pct;
    int unsigned     rx_idle_pct;
    bit              hold_request;

    diagonal_associative_memory dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    always #4 clk = ~clk;

    function automatic item_t make_cmd(logic [2:0] kind, int a, int b, int dest,
                                       logic [1:0] fn, logic [WORD_W-1:0] win,
                                       logic [KEY_W-1:0] key);
        item_t cmd;
        cmd.kind       = kind;
        cmd.index_a    = a[ROW_W-1:0];
        cmd.index_b    = b[ROW_W-1:0];
        cmd.index_dest = dest[ROW_W-1:0];
        cmd.logic_func = fn;
        cmd.word_in    = win;
        cmd.key        = key;
        return cmd;
    endfunction

    // Random command; fields a kind ignores are still random
    function automatic item_t random_cmd();
        item_t       cmd;
        int unsigned sel;
        cmd = make_cmd(KIND_READ, $urandom_range(15), $urandom_range(15), $urandom_range(15),
                       2'($urandom_range(3)), 16'($urandom), 3'($urandom_range(7)));
        sel = $urandom_range(99);
        if (sel < 22)
            cmd.kind = KIND_WRITE;
        else if (sel < 38)
            cmd.kind = KIND_READ;
        else if (sel < 56)
            cmd.kind = KIND_LOGIC;
        else if (sel < 76)
        begin
            cmd.kind = KIND_ADD;
            // aim the key at a stored word half of the time so adds hit
            if ($urandom_range(1))
                cmd.key = model.words[$urandom_range(15)][15:13];
        end
        else if (sel < 94)
            cmd.kind = KIND_COLUMN;
        else
            cmd.kind = KIND_SPARE_5 + 3'($urandom_range(2));
        return cmd;
    endfunction

    // Offer one command word, idling first at random, and hold it until taken
    task automatic push_command(item_t cmd);
        if ($urandom_range(99) < tx_idle_pct)
        begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < tx_idle_pct);
        end
        in_valid <= 1'b1;
        in_data  <= cmd;
        do
            @(posedge clk);
        while (!in_ready);
        model.note_command(cmd);
    endtask

    task automatic push_random(int count);
        repeat (count)
            push_command(random_cmd());
    endtask

    // Take result words, stalling at random or for a long hold-off on request
    initial
    begin
        int unsigned hold_left;
        hold_left = 0;
        out_ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (out_valid && out_ready)
                model.check_result(out_data);
            if (hold_request)
            begin
                hold_request = 1'b0;
                hold_left    = HOLD_OFF_CYCLES;
            end
            if (hold_left > 0)
                hold_left--;
            out_ready <= (hold_left == 0) && ($urandom_range(99) >= rx_idle_pct);
        end
    end

    initial
    begin
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        in_data      = '0;
        hold_request = 1'b0;
        tx_idle_pct  = 10;
        rx_idle_pct  = 54;
        repeat (3)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: reads and columns of the cleared matrix, extreme words, adds, logic ops, unused kinds
        push_command(make_cmd(KIND_READ, 0, 0, 0, FN_XOR, 16'h0000, 3'd0));
        push_command(make_cmd(KIND_COLUMN, 0, 0, 0, FN_XOR, 16'h0000, 3'd0));
        push_command(make_cmd(KIND_WRITE, 0, 15, 15, FN_OR_NOT_B, 16'hFFFF, 3'd7));
        push_command(make_cmd(KIND_WRITE, 15, 0, 0, FN_XOR, 16'h8001, 3'd0));
        push_command(make_cmd(KIND_WRITE, 7, 0, 0, FN_XOR, 16'h0000, 3'd0));
        push_command(make_cmd(KIND_READ, 0, 0, 0, FN_XOR, 16'h0000, 3'd0));
        push_command(make_cmd(KIND_READ, 15, 0, 0, FN_XOR, 16'hFFFF, 3'd7));
        push_command(make_cmd(KIND_COLUMN, 0, 0, 0, FN_XOR, 16'h0000, 3'd0));
        push_command(make_cmd(KIND_COLUMN, 15, 0, 0, FN_XOR, 16'h0000, 3'd0));
        // key 5 with both fields at fifteen, so the sum needs the carry bit
        push_command(make_cmd(KIND_WRITE, 3, 0, 0, FN_XOR, 16'hBFE0, 3'd0));
        push_command(make_cmd(KIND_WRITE, 9, 0, 0, FN_XOR, 16'hA000, 3'd0));
        push_command(make_cmd(KIND_ADD, 0, 0, 0, FN_XOR, 16'h0000, 3'd5));
        push_command(make_cmd(KIND_READ, 3, 0, 0, FN_XOR, 16'h0000, 3'd0));
        push_command(make_cmd(KIND_ADD, 0, 0, 0, FN_XOR, 16'h0000, 3'd7));
        push_command(make_cmd(KIND_ADD, 0, 0, 0, FN_XOR, 16'h0000, 3'd0));
        push_command(make_cmd(KIND_LOGIC, 0, 15, 1, FN_XOR, 16'h0000, 3'd0));
        // destination equal to both operands
        push_command(make_cmd(KIND_LOGIC, 1, 1, 1, FN_XNOR, 16'h0000, 3'd0));
        push_command(make_cmd(KIND_LOGIC, 5, 0, 0, FN_NOT_B, 16'h0000, 3'd0));
        push_command(make_cmd(KIND_LOGIC, 15, 3, 15, FN_OR_NOT_B, 16'h0000, 3'd0));
        push_command(make_cmd(KIND_READ, 1, 0, 0, FN_XOR, 16'h0000, 3'd0));
        push_command(make_cmd(KIND_READ, 15, 0, 0, FN_XOR, 16'h0000, 3'd0));
        push_command(make_cmd(KIND_SPARE_5, 3, 3, 3, FN_XOR, 16'hFFFF, 3'd7));
        push_command(make_cmd(KIND_SPARE_6, 9, 9, 9, FN_NOT_B, 16'h1234, 3'd5));
        push_command(make_cmd(KIND_SPARE_7, 15, 15, 15, FN_OR_NOT_B, 16'hFFFF, 3'd7));
        push_command(make_cmd(KIND_COLUMN, 7, 0, 0, FN_XOR, 16'h0000, 3'd0));

        // Random: sender idles lightly, receiver heavily
        push_random(580);

        // Swap the idling sides
        tx_idle_pct = 54;
        rx_idle_pct = 10;
        push_random(580);

        // No idling, with one long receiver hold-off to back up the input
        tx_idle_pct  = 0;
        rx_idle_pct  = 0;
        hold_request = 1'b1;
        push_random(590);
        in_valid <= 1'b0;

        // Drain outstanding result words, then watch for strays
        while (model.results_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);

        if (model.errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    // Stop a hung run
    initial
    begin
        #4_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule
